@@ sv/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, register indexes, reset values and arithmetic constants for
// the barometric pressure compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int SIDE_W     = 50;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AA    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B0    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B4    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_B6_B8 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BC_BE = 4'd7;

  // reset values
  localparam logic [15:0] RST_AA    = 16'd408;
  localparam logic [15:0] RST_AC    = 16'hFFB8;
  localparam logic [15:0] RST_AE    = 16'hC7D1;
  localparam logic [15:0] RST_B0    = 16'd32741;
  localparam logic [15:0] RST_B2    = 16'd32757;
  localparam logic [15:0] RST_B4    = 16'd23153;
  localparam logic [31:0] RST_B6_B8 = 32'd405667844;
  localparam logic [31:0] RST_BC_BE = 32'd3724086068;

  // arithmetic constants
  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] B7_GAIN    = 32'd50000;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] P_SQ_GAIN  = 32'd3038;
  localparam logic [31:0] P_LIN_GAIN = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_OFFSET   = 32'd3791;
  localparam logic [31:0] B4_BIAS    = 32'd32768;
  localparam logic [31:0] ROUND_TWO  = 32'd2;
  // divide by 100 as multiply by reciprocal, exact over 32-bit magnitudes
  localparam logic [31:0] RECIP_100  = 32'h51EB_851F;
  localparam int          RECIP_SH   = 37;

  // calibration words, sign or zero extended to 32 bits
  typedef struct packed {
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic [31:0] c4;
    logic [31:0] c5;
    logic [31:0] c6;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] mc;
    logic [31:0] md;
  } cal_t;

  // word handed from the front to the back through the queue
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] den;
    logic [15:0] up;
    logic        fault;
  } q_item_t;

  // queue status
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef logic [SIDE_W-1:0] side_t;

  function automatic logic [31:0] sra32(input logic [31:0] v, input logic [5:0] s);
    sra32 = $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] neg32(input logic [31:0] v);
    neg32 = 32'd0 - v;
  endfunction

endpackage

`default_nettype wire

@@ sv/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front
// Accepts raw words and computes the temperature term X1 and its divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [15:0]       raw_t,
  input  wire logic [15:0]       raw_p,
  input  wire bpc_pkg::cal_t     cal,
  output logic                   push,
  output bpc_pkg::q_item_t       item
);

  logic        v0_r, v1_r, v2_r;
  logic [15:0] ut_r, up0_r, up1_r, up2_r;
  logic [31:0] prod_r, t1_r, den_r;
  logic [31:0] diff;
  logic [31:0] t1_nxt;

  assign diff   = {16'd0, ut_r} - cal.c6;
  assign t1_nxt = bpc_pkg::sra32(prod_r, 6'd15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ut_r  <= raw_t;
      up0_r <= raw_p;
    end
    prod_r <= diff * cal.c5;
    up1_r  <= up0_r;
    t1_r   <= t1_nxt;
    den_r  <= t1_nxt + cal.md;
    up2_r  <= up1_r;
  end

  assign push       = v2_r;
  assign item.t1    = t1_r;
  assign item.den   = den_r;
  assign item.up    = up2_r;
  assign item.fault = (den_r == 32'd0);

endmodule

`default_nettype wire

@@ sv/bpc_queue.sv @@
// ----------------------------------------------------------------------------
// bpc_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bpc_pkg::q_item_t  wr_item,
  input  wire logic              rd_ready,
  output logic                   rd_valid,
  output bpc_pkg::q_item_t       rd_item,
  output bpc_pkg::q_stat_t       stat
);

  bpc_pkg::q_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign rd_valid = (cnt_r != 2'd0);
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem_r[rp_r];

  assign stat.push     = push;
  assign stat.pop      = pop;
  assign stat.full     = (cnt_r == 2'd2);
  assign stat.nonempty = rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full && !pop))
    else $error("queue overflow");

endmodule

`default_nettype wire

@@ sv/bpc_div.sv @@
// ----------------------------------------------------------------------------
// bpc_div
// Unsigned 32 / 32 restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [31:0]       in_num,
  input  wire logic [31:0]       in_den,
  input  wire bpc_pkg::side_t    in_side,
  output logic                   out_valid,
  output logic [31:0]            out_quo,
  output bpc_pkg::side_t         out_side
);

  logic           v_r    [32];
  logic [31:0]    rem_r  [32];
  logic [31:0]    num_r  [32];
  logic [31:0]    quo_r  [32];
  logic [31:0]    den_r  [32];
  bpc_pkg::side_t side_r [32];

  logic           v_p    [32];
  logic [31:0]    rem_p  [32];
  logic [31:0]    num_p  [32];
  logic [31:0]    quo_p  [32];
  logic [31:0]    den_p  [32];
  bpc_pkg::side_t side_p [32];

  logic [31:0]    rem_nxt [32];
  logic [31:0]    quo_nxt [32];

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      if (k == 0) begin
        v_p[k]    = in_valid;
        rem_p[k]  = 32'd0;
        num_p[k]  = in_num;
        quo_p[k]  = 32'd0;
        den_p[k]  = in_den;
        side_p[k] = in_side;
      end else begin
        v_p[k]    = v_r[k-1];
        rem_p[k]  = rem_r[k-1];
        num_p[k]  = num_r[k-1];
        quo_p[k]  = quo_r[k-1];
        den_p[k]  = den_r[k-1];
        side_p[k] = side_r[k-1];
      end
    end
  end

  always_comb begin
    logic [32:0] cand;
    logic [32:0] diff;
    for (int k = 0; k < 32; k++) begin
      cand = {rem_p[k], num_p[k][31]};
      diff = cand - {1'b0, den_p[k]};
      if (cand >= {1'b0, den_p[k]}) begin
        rem_nxt[k] = diff[31:0];
        quo_nxt[k] = {quo_p[k][30:0], 1'b1};
      end else begin
        rem_nxt[k] = cand[31:0];
        quo_nxt[k] = {quo_p[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 32; k++) v_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < 32; k++) v_r[k] <= v_p[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 32; k++) begin
      rem_r[k]  <= rem_nxt[k];
      num_r[k]  <= {num_p[k][30:0], 1'b0};
      quo_r[k]  <= quo_nxt[k];
      den_r[k]  <= den_p[k];
      side_r[k] <= side_p[k];
    end
  end

  assign out_valid = v_r[31];
  assign out_quo   = quo_r[31];
  assign out_side  = side_r[31];

endmodule

`default_nettype wire

@@ sv/bpc_back.sv @@
// ----------------------------------------------------------------------------
// bpc_back
// Finishes B5, B3, B4, B7, the pressure quotient, its correction and the hPa scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpc_pkg::cal_t     cal,
  input  wire logic              in_valid,
  input  wire bpc_pkg::q_item_t  in_item,
  output logic                   out_strobe,
  output logic [15:0]            out_pressure,
  output logic                   out_fault
);

  // valid chain outside the dividers
  logic v_p0_r, v_r1_r, v_r2_r, v_r3_r, v_r4_r, v_r5_r, v_r6_r, v_r7_r;
  logic v_r9_r, v_r10_r, v_r11_r, v_r12_r, v_r13_r, v_r14_r, v_out_r;

  // first divide
  logic [31:0]    na_r, nb_r;
  bpc_pkg::side_t s1_r;
  logic [31:0]    a_sh;
  logic           d1_v;
  logic [31:0]    d1_q;
  bpc_pkg::side_t d1_s;

  logic [31:0] t1_1_r, t2_1_r, b6_r;
  logic [15:0] up1_r, up2_r, up3_r, up4_r, up5_r;
  logic        f1_r, f2_r, f3_r, f4_r, f5_r, f6_r, f7_r;
  logic [31:0] b6b6_r, c2b6_r, c3b6_r;
  logic [31:0] x1_r, x2_r, t2a_r, t1b_r;
  logic [31:0] b3_r, t3_r, t3p_r, upb_r, b4_r, b7_r;
  logic [31:0] sq;

  // second divide
  logic           d2_v;
  logic [31:0]    d2_q;
  bpc_pkg::side_t d2_s;
  bpc_pkg::side_t s2;
  logic [31:0]    num2;

  logic [31:0] p9_r, p10_r, p11_r, aa_r, m2_r, m3_r, m2s_r, p12_r, mag_r;
  logic        f9_r, f10_r, f11_r, f12_r, f13_r, f14_r;
  logic        n13_r, n14_r;
  logic [63:0] prod_r;
  logic [31:0] a8;
  logic [26:0] qq;
  logic [31:0] res;
  logic [15:0] pres_r;
  logic        fout_r;

  assign a_sh = {cal.mc[20:0], 11'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p0_r <= 1'b0; v_r1_r <= 1'b0; v_r2_r <= 1'b0; v_r3_r <= 1'b0;
      v_r4_r <= 1'b0; v_r5_r <= 1'b0; v_r6_r <= 1'b0; v_r7_r <= 1'b0;
      v_r9_r <= 1'b0; v_r10_r <= 1'b0; v_r11_r <= 1'b0; v_r12_r <= 1'b0;
      v_r13_r <= 1'b0; v_r14_r <= 1'b0; v_out_r <= 1'b0;
    end else begin
      v_p0_r  <= in_valid;
      v_r1_r  <= d1_v;
      v_r2_r  <= v_r1_r;
      v_r3_r  <= v_r2_r;
      v_r4_r  <= v_r3_r;
      v_r5_r  <= v_r4_r;
      v_r6_r  <= v_r5_r;
      v_r7_r  <= v_r6_r;
      v_r9_r  <= d2_v;
      v_r10_r <= v_r9_r;
      v_r11_r <= v_r10_r;
      v_r12_r <= v_r11_r;
      v_r13_r <= v_r12_r;
      v_r14_r <= v_r13_r;
      v_out_r <= v_r14_r;
    end
  end

  // signed divide as magnitudes, sign restored after the divider
  always_ff @(posedge clk) begin
    na_r <= a_sh[31] ? bpc_pkg::neg32(a_sh) : a_sh;
    nb_r <= in_item.den[31] ? bpc_pkg::neg32(in_item.den) : in_item.den;
    s1_r <= {a_sh[31] ^ in_item.den[31], in_item.t1, in_item.up, in_item.fault};
  end

  bpc_div u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v_p0_r),
    .in_num   (na_r),
    .in_den   (nb_r),
    .in_side  (s1_r),
    .out_valid(d1_v),
    .out_quo  (d1_q),
    .out_side (d1_s)
  );

  assign sq = bpc_pkg::sra32(b6b6_r, 6'd12);

  always_ff @(posedge clk) begin
    t2_1_r <= d1_s[49] ? bpc_pkg::neg32(d1_q) : d1_q;
    t1_1_r <= d1_s[48:17];
    up1_r  <= d1_s[16:1];
    f1_r   <= d1_s[0];

    b6_r   <= t1_1_r + t2_1_r - bpc_pkg::B6_OFFSET;
    up2_r  <= up1_r;
    f2_r   <= f1_r;

    b6b6_r <= b6_r * b6_r;
    c2b6_r <= cal.c2 * b6_r;
    c3b6_r <= cal.c3 * b6_r;
    up3_r  <= up2_r;
    f3_r   <= f2_r;

    x1_r   <= cal.k2 * sq;
    x2_r   <= cal.k1 * sq;
    t2a_r  <= bpc_pkg::sra32(c2b6_r, 6'd11);
    t1b_r  <= bpc_pkg::sra32(c3b6_r, 6'd13);
    up4_r  <= up3_r;
    f4_r   <= f3_r;

    b3_r   <= bpc_pkg::sra32({cal.c1[29:0], 2'd0} + bpc_pkg::sra32(x1_r, 6'd11)
                             + t2a_r + bpc_pkg::ROUND_TWO, 6'd2);
    t3_r   <= bpc_pkg::sra32(t1b_r + bpc_pkg::sra32(x2_r, 6'd16)
                             + bpc_pkg::ROUND_TWO, 6'd2);
    up5_r  <= up4_r;
    f5_r   <= f4_r;

    t3p_r  <= t3_r + bpc_pkg::B4_BIAS;
    upb_r  <= {16'd0, up5_r} - b3_r;
    f6_r   <= f5_r;

    b4_r   <= (cal.c4 * t3p_r) >> 15;
    b7_r   <= upb_r * bpc_pkg::B7_GAIN;
    f7_r   <= f6_r;
  end

  // double before dividing while it fits, else after
  assign num2 = (b7_r < bpc_pkg::SIGN_BIT) ? {b7_r[30:0], 1'b0} : b7_r;
  assign s2   = {{(bpc_pkg::SIDE_W-2){1'b0}}, (b7_r < bpc_pkg::SIGN_BIT),
                 f7_r || (b4_r == 32'd0)};

  bpc_div u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v_r7_r),
    .in_num   (num2),
    .in_den   (b4_r),
    .in_side  (s2),
    .out_valid(d2_v),
    .out_quo  (d2_q),
    .out_side (d2_s)
  );

  assign a8  = bpc_pkg::sra32(p9_r, 6'd8);
  assign qq  = prod_r[bpc_pkg::RECIP_SH +: 27];
  assign res = n14_r ? bpc_pkg::neg32({5'd0, qq}) : {5'd0, qq};

  always_ff @(posedge clk) begin
    p9_r   <= d2_s[1] ? d2_q : {d2_q[30:0], 1'b0};
    f9_r   <= d2_s[0];

    aa_r   <= a8 * a8;
    m2_r   <= bpc_pkg::P_LIN_GAIN * p9_r;
    p10_r  <= p9_r;
    f10_r  <= f9_r;

    m3_r   <= aa_r * bpc_pkg::P_SQ_GAIN;
    m2s_r  <= bpc_pkg::sra32(m2_r, 6'd16);
    p11_r  <= p10_r;
    f11_r  <= f10_r;

    p12_r  <= p11_r + bpc_pkg::sra32(bpc_pkg::sra32(m3_r, 6'd16) + m2s_r
                                     + bpc_pkg::P_OFFSET, 6'd4);
    f12_r  <= f11_r;

    mag_r  <= p12_r[31] ? bpc_pkg::neg32(p12_r) : p12_r;
    n13_r  <= p12_r[31];
    f13_r  <= f12_r;

    prod_r <= {32'd0, mag_r} * {32'd0, bpc_pkg::RECIP_100};
    n14_r  <= n13_r;
    f14_r  <= f13_r;

    pres_r <= f14_r ? 16'd0 : res[15:0];
    fout_r <= f14_r;
  end

  assign out_strobe   = v_out_r;
  assign out_pressure = pres_r;
  assign out_fault    = fout_r;

endmodule

`default_nettype wire

@@ sv/barometric_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Compensated pressure in hPa from raw temperature and pressure words.
// ----------------------------------------------------------------------------
// Takes one word (raw temperature, raw pressure) on any cycle where start is
// high and busy is low, one word per clock sustained. The result appears on
// out_* for exactly one cycle, flagged by out_strobe, after passing through
// the two 32-stage pipelined dividers (temperature divisor and B4) and the
// multiply stages around them. The receiver cannot stall, so results must be
// taken when strobed. A zero divisor sets out_divide_fault and forces
// out_pressure_hpa to zero. Write calibration registers only while no word
// is in flight; indexes above seven are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [15:0]                      in_raw_temperature,
  input  wire logic [15:0]                      in_raw_pressure,
  input  wire logic                             cfg_we,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                  out_strobe,
  output logic [15:0]                           out_pressure_hpa,
  output logic                                  out_divide_fault
);

  logic [15:0] aa_r, ac_r, ae_r, b0_r, b2_r, b4_r;
  logic [31:0] b6b8_r, bcbe_r;

  bpc_pkg::cal_t    cal;
  bpc_pkg::q_item_t f_item, q_item;
  bpc_pkg::q_stat_t q_stat;
  logic             accept, f_push, q_valid;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aa_r   <= bpc_pkg::RST_AA;
      ac_r   <= bpc_pkg::RST_AC;
      ae_r   <= bpc_pkg::RST_AE;
      b0_r   <= bpc_pkg::RST_B0;
      b2_r   <= bpc_pkg::RST_B2;
      b4_r   <= bpc_pkg::RST_B4;
      b6b8_r <= bpc_pkg::RST_B6_B8;
      bcbe_r <= bpc_pkg::RST_BC_BE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::REG_AA:    aa_r   <= cfg_data[15:0];
        bpc_pkg::REG_AC:    ac_r   <= cfg_data[15:0];
        bpc_pkg::REG_AE:    ae_r   <= cfg_data[15:0];
        bpc_pkg::REG_B0:    b0_r   <= cfg_data[15:0];
        bpc_pkg::REG_B2:    b2_r   <= cfg_data[15:0];
        bpc_pkg::REG_B4:    b4_r   <= cfg_data[15:0];
        bpc_pkg::REG_B6_B8: b6b8_r <= cfg_data;
        bpc_pkg::REG_BC_BE: bcbe_r <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // extend calibration words once for both halves
  assign cal.c1 = {{16{aa_r[15]}}, aa_r};
  assign cal.c2 = {{16{ac_r[15]}}, ac_r};
  assign cal.c3 = {{16{ae_r[15]}}, ae_r};
  assign cal.c4 = {16'd0, b0_r};
  assign cal.c5 = {16'd0, b2_r};
  assign cal.c6 = {16'd0, b4_r};
  assign cal.k1 = {{16{b6b8_r[31]}}, b6b8_r[31:16]};
  assign cal.k2 = {{16{b6b8_r[15]}}, b6b8_r[15:0]};
  assign cal.mc = {{16{bcbe_r[31]}}, bcbe_r[31:16]};
  assign cal.md = {{16{bcbe_r[15]}}, bcbe_r[15:0]};

  // hold off input only if the queue has filled
  assign busy   = q_stat.full;
  assign accept = start && !busy;

  bpc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .raw_t (in_raw_temperature),
    .raw_p (in_raw_pressure),
    .cal   (cal),
    .push  (f_push),
    .item  (f_item)
  );

  // back end never stalls, so pop whenever a word waits
  bpc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_item (f_item),
    .rd_ready(1'b1),
    .rd_valid(q_valid),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  bpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cal         (cal),
    .in_valid    (q_valid),
    .in_item     (q_item),
    .out_strobe  (out_strobe),
    .out_pressure(out_pressure_hpa),
    .out_fault   (out_divide_fault)
  );

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_divide_fault |-> out_pressure_hpa == 16'd0)
    else $error("fault result with nonzero pressure");

  a_pop_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.nonempty |-> q_stat.pop)
    else $error("queue word left waiting");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.push |=> !q_stat.full)
    else $error("queue filled with a free-running back end");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometric pressure compensation testbench
// Drives raw temperature/pressure words under a range of calibration
// settings, predicts each compensated pressure in hPa and the divide fault
// flag, and compares every strobed result in order against the prediction.
// ----------------------------------------------------------------------------

module testbench;

  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 4000;

  // indexes past the register list, expected to be dropped
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] IDX_PAST_LAST = 4'd8;
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] IDX_TOP       = 4'd15;

  typedef struct packed {
    logic [15:0] hpa;
    logic        fault;
  } pressure_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_raw_temperature;
  logic [15:0] in_raw_pressure;
  logic        cfg_we;
  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic        out_strobe;
  logic [15:0] out_pressure_hpa;
  logic        out_divide_fault;

  // calibration shadow, indexed as the register file
  logic [31:0] cal_shadow [0:7];
  pressure_t   pending_hpa [$];
  int          fail_count;
  int          idle_cycles;
  bit          gaps_on;

  barometric_pressure_compensation u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_pressure_hpa   (out_pressure_hpa),
    .out_divide_fault   (out_divide_fault)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  // Compute the compensated pressure from the shadow calibration.
  function automatic pressure_t compensate(input logic [15:0] ut, input logic [15:0] up);
    logic [31:0] c1, c2, c3, c4, c5, c6, k1, k2, mc, md;
    logic [31:0] t1, t2, t3, den, b5, b6, sq, b3, b4, b7, p;
    pressure_t   r;
    c1 = sx16(cal_shadow[bpc_pkg::REG_AA][15:0]);
    c2 = sx16(cal_shadow[bpc_pkg::REG_AC][15:0]);
    c3 = sx16(cal_shadow[bpc_pkg::REG_AE][15:0]);
    c4 = {16'd0, cal_shadow[bpc_pkg::REG_B0][15:0]};
    c5 = {16'd0, cal_shadow[bpc_pkg::REG_B2][15:0]};
    c6 = {16'd0, cal_shadow[bpc_pkg::REG_B4][15:0]};
    k1 = sx16(cal_shadow[bpc_pkg::REG_B6_B8][31:16]);
    k2 = sx16(cal_shadow[bpc_pkg::REG_B6_B8][15:0]);
    mc = sx16(cal_shadow[bpc_pkg::REG_BC_BE][31:16]);
    md = sx16(cal_shadow[bpc_pkg::REG_BC_BE][15:0]);
    r  = '0;
    t1  = asr(({16'd0, ut} - c6) * c5, 15);
    den = t1 + md;
    if (den == 32'd0) begin
      r.fault = 1'b1;
      return r;
    end
    // signed divide truncates toward zero; guard the one overflow case
    if ((mc << 11) == 32'h8000_0000 && den == 32'hFFFF_FFFF) t2 = 32'h8000_0000;
    else t2 = $unsigned($signed(mc << 11) / $signed(den));
    b5 = t1 + t2;
    b6 = b5 - 32'd4000;
    sq = asr(b6 * b6, 12);
    t1 = asr(k2 * sq, 11);
    t2 = asr(c2 * b6, 11);
    t3 = t1 + t2;
    b3 = asr(c1 * 32'd4 + t3 + 32'd2, 2);
    t1 = asr(c3 * b6, 13);
    t2 = asr(k1 * sq, 16);
    t3 = asr(t1 + t2 + 32'd2, 2);
    b4 = (c4 * (t3 + 32'd32768)) >> 15;
    if (b4 == 32'd0) begin
      r.fault = 1'b1;
      return r;
    end
    b7 = ({16'd0, up} - b3) * 32'd50000;
    if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    t1 = asr(p, 8);
    t1 = t1 * t1;
    t1 = asr(t1 * 32'd3038, 16);
    t2 = asr((32'd0 - 32'd7357) * p, 16);
    p  = p + asr(t1 + t2 + 32'd3791, 4);
    t1 = $unsigned($signed(p) / 32'sd100);
    r.hpa = t1[15:0];
    return r;
  endfunction

  // Check each strobed word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_hpa.size() == 0) begin
        $display("%0t: unexpected result hpa=%0d fault=%0b", $time,
                 out_pressure_hpa, out_divide_fault);
        fail_count++;
      end else begin
        pressure_t want;
        want = pending_hpa.pop_front();
        if (out_pressure_hpa !== want.hpa) begin
          $display("%0t: pressure_hpa expected %0d actual %0d", $time,
                   want.hpa, out_pressure_hpa);
          fail_count++;
        end
        if (out_divide_fault !== want.fault) begin
          $display("%0t: divide_fault expected %0b actual %0b", $time,
                   want.fault, out_divide_fault);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with nothing accepted on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Write one calibration register; block must be idle. Drop the enable
  // after each write so back-to-back writes never double-drive it.
  task automatic write_cal(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= bpc_pkg::REG_B4) cal_shadow[idx] = {16'd0, val[15:0]};
    else if (idx <= bpc_pkg::REG_BC_BE) cal_shadow[idx] = val;
    @(posedge clk);
  endtask

  // Send one word, idling at random first; hold start until accepted.
  task automatic send_word(input logic [15:0] ut, input logic [15:0] up);
    while (gaps_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure    <= up;
    do @(posedge clk); while (busy);
    pending_hpa.push_back(compensate(ut, up));
    // start is lowered by the caller's next send when it idles, or by drain
  endtask

  // Drop start, wait for all results, then let the pipe settle.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_hpa.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_cal(input logic [15:0] aa, ac, ae, b0, b2, b4,
                          input logic [31:0] b6b8, bcbe);
    write_cal(bpc_pkg::REG_AA, {16'd0, aa});
    write_cal(bpc_pkg::REG_AC, {16'd0, ac});
    write_cal(bpc_pkg::REG_AE, {16'd0, ae});
    write_cal(bpc_pkg::REG_B0, {16'd0, b0});
    write_cal(bpc_pkg::REG_B2, {16'd0, b2});
    write_cal(bpc_pkg::REG_B4, {16'd0, b4});
    write_cal(bpc_pkg::REG_B6_B8, b6b8);
    write_cal(bpc_pkg::REG_BC_BE, bcbe);
  endtask

  task automatic load_reset_cal;
    load_cal(bpc_pkg::RST_AA, bpc_pkg::RST_AC, bpc_pkg::RST_AE, bpc_pkg::RST_B0,
             bpc_pkg::RST_B2, bpc_pkg::RST_B4, bpc_pkg::RST_B6_B8,
             bpc_pkg::RST_BC_BE);
  endtask

  // Field extremes and typical readings at reset calibration.
  task automatic test_extremes;
    send_word(16'd27898, 16'd23843);
    send_word(16'h0000, 16'h0000);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'hFFFF, 16'h0000);
    send_word(16'h5555, 16'hAAAA);
    send_word(16'hAAAA, 16'h5555);
    send_word(16'd23153, 16'd40000);
    drain();
  endtask

  // Zero temperature divisor: MD = 0 and UT = AC6 makes X1 + MD zero.
  task automatic test_temp_divisor_zero;
    write_cal(bpc_pkg::REG_BC_BE, {bpc_pkg::RST_BC_BE[31:16], 16'd0});
    send_word(bpc_pkg::RST_B4, 16'd30000);
    send_word(bpc_pkg::RST_B4, 16'd0);
    send_word(16'd30000, 16'd30000);
    drain();
    load_reset_cal();
  endtask

  // Zero pressure divisor: AC4 = 0 forces B4 to zero.
  task automatic test_b4_zero;
    write_cal(bpc_pkg::REG_B0, 32'd0);
    send_word(16'd27898, 16'd23843);
    send_word(16'hFFFF, 16'h1234);
    drain();
    load_reset_cal();
  endtask

  // Ignored index beyond the register file.
  task automatic test_bad_index;
    write_cal(IDX_PAST_LAST, 32'hFFFF_FFFF);
    write_cal(IDX_TOP, 32'h0);
    send_word(16'd27898, 16'd23843);
    drain();
  endtask

  // Extreme calibration settings, with wrapping intermediates.
  task automatic test_cal_extremes;
    load_cal(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             32'h7FFF_7FFF, 32'h7FFF_7FFF);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'hFFFF, 16'h0000);
    drain();
    load_cal(16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'h0000, 16'h0000,
             32'h8000_8000, 32'h8000_8000);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'hFFFF, 16'h8000);
    drain();
    load_cal(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001,
             32'h0, 32'hFFFF_FFFF);
    send_word(16'h0001, 16'h0001);
    drain();
    load_reset_cal();
  endtask

  // Random words across several calibration sets; gaps off in one phase.
  task automatic test_random;
    int unsigned phase, n;
    logic [15:0] ut, up;
    for (phase = 0; phase < 7; phase++) begin
      if (phase == 0) load_reset_cal();
      else if (phase == 6) load_cal(16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      else load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), $urandom, $urandom);
      gaps_on = (phase != 2);
      for (n = 0; n < 250; n++) begin
        ut = 16'($urandom);
        up = 16'($urandom);
        if ($urandom_range(3) == 0)
          ut = 16'(cal_shadow[bpc_pkg::REG_B4][15:0] + $urandom_range(8) - 4);
        send_word(ut, up);
      end
      drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n              = 1'b0;
    start              = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure    = '0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    fail_count         = 0;
    idle_cycles        = 0;
    gaps_on            = 1'b1;
    cal_shadow[bpc_pkg::REG_AA]    = {16'd0, bpc_pkg::RST_AA};
    cal_shadow[bpc_pkg::REG_AC]    = {16'd0, bpc_pkg::RST_AC};
    cal_shadow[bpc_pkg::REG_AE]    = {16'd0, bpc_pkg::RST_AE};
    cal_shadow[bpc_pkg::REG_B0]    = {16'd0, bpc_pkg::RST_B0};
    cal_shadow[bpc_pkg::REG_B2]    = {16'd0, bpc_pkg::RST_B2};
    cal_shadow[bpc_pkg::REG_B4]    = {16'd0, bpc_pkg::RST_B4};
    cal_shadow[bpc_pkg::REG_B6_B8] = bpc_pkg::RST_B6_B8;
    cal_shadow[bpc_pkg::REG_BC_BE] = bpc_pkg::RST_BC_BE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_temp_divisor_zero();
    test_b4_zero();
    test_bad_index();
    test_cal_extremes();
    test_random();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bpc_pkg.sv
sv/bpc_front.sv
sv/bpc_queue.sv
sv/bpc_div.sv
sv/bpc_back.sv
sv/barometric_pressure_compensation.sv
verif/testbench.sv
